[hdl/nfmb_pkg.sv]
// ----------------------------------------------------------------------------
// nfmb_pkg
// Types and constants shared by the sixteen-tone FSK message beacon.
// ----------------------------------------------------------------------------
package nfmb_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W = 16;
  localparam int SCALE_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COMPARE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SCALE = 2'd2;

  localparam logic [CNT_W-1:0] SYMBOL_PERIOD_RST = 16'd2097;
  localparam logic [CNT_W-1:0] START_COMPARE_RST = 16'd15624;
  localparam logic [SCALE_W-1:0] PERIOD_SCALE_RST = 12'd5;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [8:0] CSUM_MOD = 9'd255;
  localparam logic [7:0] TRAILER_BYTE = 8'h00;

  typedef struct packed {
    logic       carrier_level;
    logic       symbol_marker;
    logic       sending;
    logic [7:0] checksum_value;
  } res_t;

endpackage

[hdl/nfmb_core.sv]
// ----------------------------------------------------------------------------
// nfmb_core
// Message store, checksum, framing and the symbol and carrier timers.
// ----------------------------------------------------------------------------
module nfmb_core #(
  parameter int MSG_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           mode,
  input  logic [7:0]                     data_byte,
  input  logic                           last,
  input  logic                           cfg_we,
  input  logic [nfmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfmb_pkg::CFG_DATA_W-1:0] cfg_data,
  output nfmb_pkg::res_t                 res
);
  import nfmb_pkg::*;

  localparam int ADDR_W = $clog2(MSG_DEPTH);
  localparam int IDX_W = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] BODY_MAX = ADDR_W'(MSG_DEPTH - 2);

  logic [CNT_W-1:0]   symbol_period;
  logic [CNT_W-1:0]   start_compare;
  logic [SCALE_W-1:0] period_scale;

  logic [7:0]        mem [MSG_DEPTH];
  logic [7:0]        mem_q;

  logic [ADDR_W-1:0] body_len, body_len_next;
  logic [7:0]        checksum, checksum_next;
  logic [IDX_W-1:0]  sym_idx, sym_idx_next;
  logic [CNT_W-1:0]  sym_cnt, sym_cnt_next;
  logic [CNT_W-1:0]  car_cnt, car_cnt_next;
  logic [CNT_W-1:0]  car_cmp, car_cmp_next;
  logic              carrier, carrier_next;
  logic              marker, marker_next;
  logic              sending_flag, sending_flag_next;

  logic [ADDR_W-1:0] base_len;
  logic [7:0]        base_sum;
  logic              take;
  logic [8:0]        sum_raw;
  logic [7:0]        sum_mod;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;

  logic [ADDR_W-1:0] byte_addr;
  logic [7:0]        sym_byte;
  logic [3:0]        nibble;
  logic [SCALE_W+4:0] tone_product;
  logic [IDX_W:0]    nsym;
  logic [IDX_W:0]    idx_inc;
  logic [IDX_W-1:0]  idx_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_period <= SYMBOL_PERIOD_RST;
      start_compare <= START_COMPARE_RST;
      period_scale <= PERIOD_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYMBOL_PERIOD: symbol_period <= cfg_data;
        CFG_START_COMPARE: start_compare <= cfg_data;
        CFG_PERIOD_SCALE:  period_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // load path
  always_comb begin
    base_len = sending_flag ? '0 : body_len;
    base_sum = sending_flag ? '0 : checksum;
    take = base_len < BODY_MAX;
    sum_raw = {1'b0, base_sum} + {1'b0, data_byte};
    sum_mod = (sum_raw >= CSUM_MOD) ? 8'(sum_raw - CSUM_MOD) : sum_raw[7:0];
    mem_we = step && (mode == MODE_LOAD) && take;
  end

  // symbol path
  always_comb begin
    byte_addr = sym_idx[IDX_W-1:1];
    if (byte_addr < body_len) begin
      sym_byte = mem_q;
    end else if (byte_addr == body_len) begin
      sym_byte = checksum;
    end else begin
      sym_byte = TRAILER_BYTE;
    end
    nibble = sym_idx[0] ? sym_byte[3:0] : sym_byte[7:4];
    tone_product = ({1'b0, nibble} + 5'd1) * period_scale;
    nsym = {{1'b0, body_len} + (IDX_W)'(2), 1'b0};
    idx_inc = {1'b0, sym_idx} + (IDX_W+1)'(1);
    idx_wrap = (idx_inc == nsym) ? '0 : idx_inc[IDX_W-1:0];
  end

  always_comb begin
    body_len_next = body_len;
    checksum_next = checksum;
    sym_idx_next = sym_idx;
    sym_cnt_next = sym_cnt;
    car_cnt_next = car_cnt;
    car_cmp_next = car_cmp;
    carrier_next = carrier;
    marker_next = marker;
    sending_flag_next = sending_flag;
    if (step) begin
      case (mode)
        MODE_LOAD: begin
          body_len_next = take ? base_len + ADDR_W'(1) : base_len;
          checksum_next = take ? sum_mod : base_sum;
          sending_flag_next = last;
          if (last) begin
            sym_idx_next = '0;
            sym_cnt_next = '0;
            car_cnt_next = '0;
            car_cmp_next = start_compare;
            carrier_next = 1'b1;
            marker_next = 1'b0;
          end
        end
        MODE_TICK: begin
          if (sending_flag) begin
            if (car_cnt == car_cmp) begin
              car_cnt_next = '0;
              carrier_next = ~carrier;
              marker_next = 1'b0;
            end else begin
              car_cnt_next = car_cnt + CNT_W'(1);
            end
            if (sym_cnt == symbol_period) begin
              sym_cnt_next = '0;
              car_cmp_next = tone_product[CNT_W-1:0];
              car_cnt_next = '0;
              marker_next = 1'b1;
              sym_idx_next = idx_wrap;
            end else begin
              sym_cnt_next = sym_cnt + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // prefetch the byte of the upcoming symbol
  assign mem_raddr = sym_idx_next[IDX_W-1:1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[base_len] <= data_byte;
    end
    if (mem_we && (base_len == mem_raddr)) begin
      mem_q <= data_byte;
    end else begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_len <= '0;
      checksum <= '0;
      sym_idx <= '0;
      sym_cnt <= '0;
      car_cnt <= '0;
      car_cmp <= START_COMPARE_RST;
      carrier <= 1'b1;
      marker <= 1'b0;
      sending_flag <= 1'b0;
    end else begin
      body_len <= body_len_next;
      checksum <= checksum_next;
      sym_idx <= sym_idx_next;
      sym_cnt <= sym_cnt_next;
      car_cnt <= car_cnt_next;
      car_cmp <= car_cmp_next;
      carrier <= carrier_next;
      marker <= marker_next;
      sending_flag <= sending_flag_next;
    end
  end

  assign res.carrier_level = carrier;
  assign res.symbol_marker = marker;
  assign res.sending = sending_flag;
  assign res.checksum_value = checksum;

endmodule

[hdl/nibble_fsk_message_beacon_top.sv]
// ----------------------------------------------------------------------------
// nibble_fsk_message_beacon_top
// Sixteen-tone FSK beacon: loads a message, frames it with a mod-255
// checksum and repeats it as nibble symbols on a keyed carrier.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    mode, data_byte, last
//   out      source     out_valid/out_ready  carrier_level, symbol_marker,
//                                            sending, checksum_value
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_ready is high; each item gives its result in the cycle after its transfer.
// The state registers double as the result register, so a new item is taken
// only when no result waits or in the cycle the waiting result is taken.
// out_ready low with a result pending holds in_ready low.
// Synchronous reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module nibble_fsk_message_beacon_top #(
  parameter int MSG_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [7:0]                      data_byte,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            carrier_level,
  output logic                            symbol_marker,
  output logic                            sending,
  output logic [7:0]                      checksum_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nfmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfmb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nfmb_pkg::*;

  logic in_xfer;
  res_t res;

  assign in_ready = ~out_valid | out_ready;
  assign in_xfer = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  nfmb_core #(
    .MSG_DEPTH(MSG_DEPTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(in_xfer),
    .mode(mode),
    .data_byte(data_byte),
    .last(last),
    .cfg_we(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign carrier_level = res.carrier_level;
  assign symbol_marker = res.symbol_marker;
  assign sending = res.sending;
  assign checksum_value = res.checksum_value;

endmodule

[hdl/nfmb_checker.sv]
// ----------------------------------------------------------------------------
// nfmb_checker
// Port-level checks for the beacon top level, attached by bind.
// ----------------------------------------------------------------------------
module nfmb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       mode,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       carrier_level,
  input logic       symbol_marker,
  input logic       sending,
  input logic [7:0] checksum_value
);
  import nfmb_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid & in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(carrier_level) &&
      $stable(symbol_marker) && $stable(sending) && $stable(checksum_value))
    else $error("result changed while stalled");

  a_load_framing: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (mode == MODE_LOAD) |=> out_valid && (sending == $past(last)))
    else $error("sending does not follow last on a load");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (mode == MODE_TICK) && !sending |=> !sending &&
      $stable(carrier_level) && $stable(symbol_marker))
    else $error("tick changed state while not sending");

  a_tick_checksum: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (mode == MODE_TICK) |=> $stable(checksum_value) &&
      (checksum_value != 8'd255))
    else $error("checksum moved on a tick or left its range");

endmodule

bind nibble_fsk_message_beacon_top nfmb_checker u_nfmb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .mode(mode),
  .last(last),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .carrier_level(carrier_level),
  .symbol_marker(symbol_marker),
  .sending(sending),
  .checksum_value(checksum_value)
);
